>>> rtl/core/utf8_stream_decoder_defines.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// No dependencies; take in by `include before the module that asserts.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define U8DEC_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define U8DEC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/u8dec_pkg.sv
// Types, constants and result builders for the UTF-8 stream decoder.
// No dependencies; imported by utf8_stream_decoder.
package u8dec_pkg;

  localparam int unsigned CP_W      = 21;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned OUT_DEPTH = 4;

  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00fffd;
  localparam logic [CP_W-1:0] MIN_LEN2       = 21'h000080;
  localparam logic [CP_W-1:0] MIN_LEN3       = 21'h000800;
  localparam logic [CP_W-1:0] MIN_LEN4       = 21'h010000;

  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  // Register indexes on the config port
  localparam logic REG_CHECK_OVERLONG = 1'b0;
  localparam logic REG_SUBSTITUTE     = 1'b1;

  typedef enum logic [1:0] {
    KIND_VALID    = 2'd0,
    KIND_BAD      = 2'd1,
    KIND_OVERLONG = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    kind_t            error_kind;
    logic [LEN_W-1:0] seq_bytes;
    logic             text_done;
    logic             run_last;
  } res_t;

  function automatic res_t make_ok(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len);
    res_t r;
    r.code_point = cp;
    r.error_kind = KIND_VALID;
    r.seq_bytes  = len;
    r.text_done  = 1'b0;
    r.run_last   = 1'b0;
    return r;
  endfunction

  function automatic res_t make_err(input kind_t kind, input logic [LEN_W-1:0] len,
                                    input logic subst);
    res_t r;
    r.code_point = subst ? CP_REPLACEMENT : '0;
    r.error_kind = kind;
    r.seq_bytes  = len;
    r.text_done  = 1'b0;
    r.run_last   = 1'b0;
    return r;
  endfunction

  // Smallest value a sequence of this length may legally carry
  function automatic logic [CP_W-1:0] min_value(input logic [LEN_W-1:0] len);
    logic [CP_W-1:0] v;
    v = (len == LEN_TWO) ? MIN_LEN2 : (len == LEN_THREE) ? MIN_LEN3 : MIN_LEN4;
    return v;
  endfunction

endpackage

>>> rtl/core/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: byte decode, sequence state and result queue.
// Depends on u8dec_pkg and utf8_stream_decoder_defines.svh.
//
//   channel | dir | tdata                          | tuser                     | tlast
//   in_     | in  | [7:0] byte_in                  | -                         | end_of_text
//   out_    | out | [20:0] code_point, [23:21] len | [1:0] error_kind, [2] run | text_done
//   cfg_    | in  | cfg_addr: register index, cfg_data: value; always ready
//
// One input word is taken per clock; decode is a single shallow pass from the
// accepted byte and the sequence state straight into a 4-entry result queue.
// A byte yields up to two results, so in_tready needs two free queue slots.
// The out_ side drains one result per clock; back-pressure there fills the
// queue and then holds in_tready low. Reset (rst_n low, synchronous) empties
// the queue, clears both config bits and returns to start of text.
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder
  import u8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // end_of_text
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] seq_bytes
  output logic [2:0]  out_tuser,  // [1:0] error_kind, [2] run_last
  output logic        out_tlast,  // text_done
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic        cfg_data
);

  localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(OUT_DEPTH - 2);

  // configuration
  logic chk_overlong_r;
  logic subst_r;

  // sequence state
  logic [1:0]       pend_r, pend_nxt;
  logic [CP_W-1:0]  part_r, part_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             start_r, start_nxt;

  // result queue
  res_t             queue_r [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic in_fire, out_fire;
  logic [7:0] byte_in;
  logic eot;

  // byte classes
  logic is_ascii, is_cont, is_lead, is_invalid;
  logic [LEN_W-1:0] lead_len;
  logic [CP_W-1:0]  lead_bits;
  logic             first_flag;
  logic             fr_valid;
  res_t             fr;

  logic             run_fresh;
  logic [CP_W-1:0]  part_cat;
  logic [1:0]       push_n;
  res_t             res_a, res_b;

  assign byte_in  = in_tdata;
  assign eot      = in_tlast;
  assign in_tready = (cnt_r <= ROOM_LIMIT);
  assign in_fire  = in_tvalid & in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_fire = out_tvalid & out_tready;
  assign cfg_ready = 1'b1;

  // Head of the queue drives the result port
  assign out_tdata = {queue_r[rd_ptr_r].seq_bytes, queue_r[rd_ptr_r].code_point};
  assign out_tuser = {queue_r[rd_ptr_r].run_last, queue_r[rd_ptr_r].error_kind};
  assign out_tlast = queue_r[rd_ptr_r].text_done;

  // Classify the byte as it would be seen at the start of a character
  always_comb begin
    is_ascii   = ~byte_in[7];
    is_cont    = (byte_in[7:6] == 2'b10);
    lead_len   = LEN_ONE;
    lead_bits  = '0;
    is_lead    = 1'b1;
    if (byte_in[7:5] == 3'b110) begin
      lead_len  = LEN_TWO;
      lead_bits = CP_W'(byte_in[4:0]);
    end else if (byte_in[7:4] == 4'b1110) begin
      lead_len  = LEN_THREE;
      lead_bits = CP_W'(byte_in[3:0]);
    end else if (byte_in[7:3] == 5'b11110) begin
      lead_len  = LEN_FOUR;
      lead_bits = CP_W'(byte_in[2:0]);
    end else begin
      is_lead = 1'b0;
    end
    is_invalid = ~is_ascii & ~is_cont & ~is_lead;
  end

  // Result of a byte taken fresh. A stray continuation only reports at the
  // very start of a text; a lead with end of text is a truncated sequence.
  assign first_flag = (pend_r == 2'd0) & start_r;
  always_comb begin
    fr_valid = is_ascii | (is_cont & first_flag) | is_invalid | (is_lead & eot);
    if (is_ascii) begin
      fr = make_ok(CP_W'(byte_in), LEN_ONE);
    end else if (is_lead) begin
      fr = make_err(KIND_BAD, lead_len, subst_r);
    end else begin
      fr = make_err(KIND_BAD, LEN_ONE, subst_r);
    end
  end

  assign part_cat = {part_r[CP_W-7:0], byte_in[5:0]};

  // Sequence tracking and result assembly
  always_comb begin
    res_a     = '0;
    res_b     = '0;
    push_n    = 2'd0;
    pend_nxt  = pend_r;
    part_nxt  = part_r;
    len_nxt   = len_r;
    start_nxt = 1'b0;
    run_fresh = 1'b0;

    if (pend_r != 2'd0) begin
      if (is_cont) begin
        if (pend_r == 2'd1) begin
          // last continuation: close the character
          if (chk_overlong_r && (part_cat < min_value(len_r))) begin
            res_a = make_err(KIND_OVERLONG, len_r, subst_r);
          end else begin
            res_a = make_ok(part_cat, len_r);
          end
          push_n   = 2'd1;
          pend_nxt = 2'd0;
          part_nxt = '0;
          len_nxt  = LEN_ONE;
        end else begin
          pend_nxt = pend_r - 2'd1;
          part_nxt = part_cat;
          if (eot) begin
            res_a  = make_err(KIND_BAD, len_r, subst_r);
            push_n = 2'd1;
          end
        end
      end else begin
        // interrupted sequence: report it, then decode this byte afresh
        res_a     = make_err(KIND_BAD, len_r, subst_r);
        push_n    = 2'd1;
        pend_nxt  = 2'd0;
        part_nxt  = '0;
        len_nxt   = LEN_ONE;
        run_fresh = 1'b1;
      end
    end else begin
      run_fresh = 1'b1;
    end

    if (run_fresh && fr_valid) begin
      if (push_n == 2'd0) begin
        res_a = fr;
      end else begin
        res_b = fr;
      end
      push_n = push_n + 2'd1;
    end
    if (run_fresh && is_lead && !eot) begin
      pend_nxt = 2'(lead_len - LEN_ONE);
      part_nxt = lead_bits;
      len_nxt  = lead_len;
    end

    // end of text returns to the start condition
    if (eot) begin
      pend_nxt  = 2'd0;
      part_nxt  = '0;
      len_nxt   = LEN_ONE;
      start_nxt = 1'b1;
    end

    // tag the last result of this byte
    if (push_n == 2'd1) begin
      res_a.run_last  = 1'b1;
      res_a.text_done = eot;
    end else if (push_n == 2'd2) begin
      res_b.run_last  = 1'b1;
      res_b.text_done = eot;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      cnt_nxt = cnt_nxt + CNT_W'(push_n);
    end
    if (out_fire) begin
      cnt_nxt = cnt_nxt - CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_overlong_r <= 1'b0;
      subst_r        <= 1'b0;
      pend_r         <= 2'd0;
      part_r         <= '0;
      len_r          <= LEN_ONE;
      start_r        <= 1'b1;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      cnt_r          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_addr)
          REG_CHECK_OVERLONG: chk_overlong_r <= cfg_data;
          REG_SUBSTITUTE:     subst_r        <= cfg_data;
        endcase
      end
      if (in_fire) begin
        pend_r   <= pend_nxt;
        part_r   <= part_nxt;
        len_r    <= len_nxt;
        start_r  <= start_nxt;
        wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire && (push_n != 2'd0)) begin
      queue_r[wr_ptr_r] <= res_a;
    end
    if (in_fire && (push_n == 2'd2)) begin
      queue_r[wr_ptr_r + PTR_W'(1)] <= res_b;
    end
  end

  // Queue never overfills
  `U8DEC_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(OUT_DEPTH),
                    "result queue overflow")
  // An interrupted sequence always leaves a result behind
  `U8DEC_ASSERT_NEXT(a_interrupt_reports, clk, rst_n,
                     in_fire && (pend_r != 2'd0) && !is_cont, out_tvalid,
                     "interrupted sequence gave no result")
  // End of text always returns to the start condition
  `U8DEC_ASSERT_NEXT(a_eot_clears, clk, rst_n, in_fire && in_tlast,
                     (pend_r == 2'd0) && start_r, "end of text left a sequence pending")
  // A lead byte mid-text opens a sequence
  `U8DEC_ASSERT_NEXT(a_lead_opens, clk, rst_n,
                     in_fire && !in_tlast && (pend_r == 2'd0) && is_lead, pend_r != 2'd0,
                     "lead byte did not open a sequence")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for utf8_stream_decoder: streams UTF-8 texts in and checks every result word
// against a local decode model. Depends only on u8dec_pkg and the decoder RTL.

module testbench;
  import u8dec_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;        // result queue depth plus margin
  localparam int unsigned CYCLE_LIMIT   = 400_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_addr = 1'b0;
  logic        cfg_data = 1'b0;

  utf8_stream_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // Decode model state, mirrors what the decoder keeps between bytes
  logic [1:0]       cont_left;
  logic [CP_W-1:0]  cp_accum;
  logic [LEN_W-1:0] announced_len;
  logic             text_fresh;
  logic             overlong_on;
  logic             subst_on;

  res_t             expected_cps[$];   // decoded results still owed by the decoder
  logic [7:0]       text_bytes[$];     // text under construction for the random part

  bit               idle_on;
  int unsigned      fail_count = 0;
  int unsigned      words_sent;
  int unsigned      results_seen = 0;
  int unsigned      settings_used;
  int unsigned      cycle_count = 0;
  int unsigned      stall_left = 0;
  res_t             want;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hard stop in case the decoder hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------

  // Queue one result; error results carry U+FFFD or zero per the substitute bit
  function automatic void owe_result(input logic [CP_W-1:0] cp, input kind_t kind,
                                     input logic [LEN_W-1:0] len);
    res_t r;
    r.code_point = (kind == KIND_VALID) ? cp : (subst_on ? CP_REPLACEMENT : '0);
    r.error_kind = kind;
    r.seq_bytes  = len;
    r.text_done  = 1'b0;
    r.run_last   = 1'b0;
    expected_cps.push_back(r);
  endfunction

  function automatic void clear_sequence();
    cont_left     = '0;
    cp_accum      = '0;
    announced_len = LEN_ONE;
  endfunction

  // A byte seen with no continuation pending
  function automatic void decode_lead(input logic [7:0] b, input logic eot,
                                      input logic first);
    logic [LEN_W-1:0] len;
    logic [CP_W-1:0]  bits;
    if (!b[7]) begin
      owe_result({13'd0, b}, KIND_VALID, LEN_ONE);
    end else if (b[7:6] == 2'b10) begin
      // stray continuation: error only as the first byte of a text, else drop
      if (first) owe_result('0, KIND_BAD, LEN_ONE);
    end else if (b[7:3] == 5'b11111) begin
      owe_result('0, KIND_BAD, LEN_ONE);
    end else begin
      if (!b[5]) begin
        len  = LEN_TWO;
        bits = CP_W'(b[4:0]);
      end else if (!b[4]) begin
        len  = LEN_THREE;
        bits = CP_W'(b[3:0]);
      end else begin
        len  = LEN_FOUR;
        bits = CP_W'(b[2:0]);
      end
      if (eot) begin
        owe_result('0, KIND_BAD, len);
      end else begin
        cont_left     = 2'(len - 1);
        cp_accum      = bits;
        announced_len = len;
      end
    end
  endfunction

  // Advance the model by one accepted word and queue what it must produce
  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    logic            first;
    int              base;
    logic [CP_W-1:0] floor_cp;
    res_t            r;
    first      = text_fresh;
    base       = expected_cps.size();
    text_fresh = 1'b0;
    if (cont_left != 0) begin
      if (b[7:6] == 2'b10) begin
        cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 0) begin
          floor_cp = (announced_len == LEN_TWO)   ? MIN_LEN2 :
                     (announced_len == LEN_THREE) ? MIN_LEN3 : MIN_LEN4;
          if (overlong_on && cp_accum < floor_cp)
            owe_result('0, KIND_OVERLONG, announced_len);
          else
            owe_result(cp_accum, KIND_VALID, announced_len);
          clear_sequence();
        end else if (eot) begin
          owe_result('0, KIND_BAD, announced_len);
        end
      end else begin
        // interrupted sequence: report it, then treat the byte as new
        owe_result('0, KIND_BAD, announced_len);
        clear_sequence();
        decode_lead(b, eot, 1'b0);
      end
    end else begin
      decode_lead(b, eot, first);
    end
    if (eot) begin
      clear_sequence();
      text_fresh = 1'b1;
    end
    if (expected_cps.size() > base) begin
      r = expected_cps.pop_back();
      r.run_last = 1'b1;
      if (eot) r.text_done = 1'b1;
      expected_cps.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);   // hold ready low while stall_left counts down
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cps.size() == 0) begin
        $error("result word with nothing owed: code_point %0h kind %0d",
               out_tdata[20:0], out_tuser[1:0]);
        fail_count++;
      end else begin
        want = expected_cps.pop_front();
        results_seen++;
        if (out_tdata[20:0] !== want.code_point) begin
          $error("code_point expected %0h actual %0h", want.code_point, out_tdata[20:0]);
          fail_count++;
        end
        if (out_tuser[1:0] !== want.error_kind) begin
          $error("error_kind expected %0d actual %0d", want.error_kind, out_tuser[1:0]);
          fail_count++;
        end
        if (out_tdata[23:21] !== want.seq_bytes) begin
          $error("seq_bytes expected %0d actual %0d", want.seq_bytes, out_tdata[23:21]);
          fail_count++;
        end
        if (out_tlast !== want.text_done) begin
          $error("text_done expected %0d actual %0d", want.text_done, out_tlast);
          fail_count++;
        end
        if (out_tuser[2] !== want.run_last) begin
          $error("run_last expected %0d actual %0d", want.run_last, out_tuser[2]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Present one word and hold it until taken. Valid stays high afterwards so the
  // next word can follow at once; anything that lets time pass lowers it first.
  task automatic send_word(input logic [7:0] b, input logic eot);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, eot);
    words_sent++;
  endtask

  // Hold off input until every owed result is back, then let the pipe settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers; only called with the decoder idle
  task automatic set_config(input logic ovl, input logic sub);
    cfg_valid <= 1'b1;
    cfg_addr  <= REG_CHECK_OVERLONG;
    cfg_data  <= ovl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    overlong_on = ovl;
    cfg_addr  <= REG_SUBSTITUTE;
    cfg_data  <= sub;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    subst_on = sub;
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++)
      send_word(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  // Append one character to the text: mostly well-formed, sometimes broken
  function automatic void append_char();
    int unsigned     pick;
    int unsigned     len;
    int unsigned     conts;
    logic [CP_W-1:0] cp;
    pick = $urandom_range(0, 99);
    cp   = CP_W'($urandom);
    if (pick < 30) begin
      text_bytes.push_back({1'b0, cp[6:0]});
    end else if (pick < 50) begin
      text_bytes.push_back({3'b110, cp[10:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else if (pick < 65) begin
      text_bytes.push_back({4'b1110, cp[15:12]});
      text_bytes.push_back({2'b10, cp[11:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else if (pick < 80) begin
      text_bytes.push_back({5'b11110, cp[20:18]});
      text_bytes.push_back({2'b10, cp[17:12]});
      text_bytes.push_back({2'b10, cp[11:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else if (pick < 87) begin
      // sequence cut short: the next char interrupts it or the text ends on it
      len   = $urandom_range(2, 4);
      conts = $urandom_range(0, len - 2);
      case (len)
        2:       text_bytes.push_back({3'b110, cp[4:0]});
        3:       text_bytes.push_back({4'b1110, cp[3:0]});
        default: text_bytes.push_back({5'b11110, cp[2:0]});
      endcase
      repeat (conts) text_bytes.push_back({2'b10, 6'($urandom)});
    end else if (pick < 92) begin
      text_bytes.push_back({2'b10, cp[5:0]});
    end else if (pick < 96) begin
      text_bytes.push_back({5'b11111, cp[2:0]});
    end else begin
      text_bytes.push_back(8'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: both checks off. Covers byte extremes, an overlong pair
  // passed as valid, an invalid lead, and stray continuations at and after start.
  task automatic test_reset_settings();
    send_word(8'h80, 1'b0);   // stray continuation opening the text
    send_word(8'h00, 1'b0);
    send_word(8'h7f, 1'b0);
    send_word(8'hc0, 1'b0);   // overlong zero, accepted with the check off
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b0);   // invalid lead
    send_word(8'hbf, 1'b0);   // stray continuation mid-text: dropped
    send_word(8'h41, 1'b1);
  endtask

  // Multi-byte lengths, the largest 4-byte value, overlong flagged, truncation
  task automatic test_multibyte();
    drain_results();
    set_config(1'b1, 1'b1);
    send_word(8'hc2, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hef, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'hf7, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'he0, 1'b0);   // three-byte overlong
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'he2, 1'b0);
    send_word(8'h82, 1'b1);   // text ends with one continuation missing
  endtask

  // Interrupted sequence, lead on the final byte, stray continuation closing a text
  task automatic test_sequence_breaks();
    drain_results();
    set_config(1'b0, 1'b1);
    send_word(8'he2, 1'b0);
    send_word(8'h41, 1'b0);   // two results: the break, then 'A'
    send_word(8'hc3, 1'b1);
    send_word(8'h41, 1'b0);
    send_word(8'h80, 1'b1);   // no result, yet the text is closed
  endtask

  // Random texts under one register setting
  task automatic test_random_texts(input int unsigned n_words, input logic ovl,
                                   input logic sub, input bit idle);
    int unsigned start;
    int unsigned n_chars;
    drain_results();
    set_config(ovl, sub);
    idle_on = idle;
    start   = words_sent;
    while (words_sent - start < n_words) begin
      text_bytes.delete();
      n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      repeat (n_chars) append_char();
      send_text();
    end
  endtask

  initial begin
    cont_left     = '0;
    cp_accum      = '0;
    announced_len = LEN_ONE;
    text_fresh    = 1'b1;
    overlong_on   = 1'b0;
    subst_on      = 1'b0;
    idle_on       = 1'b1;
    words_sent    = 0;
    settings_used = 1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_multibyte();
    test_sequence_breaks();
    test_random_texts(300, 1'b1, 1'b0, 1'b1);
    test_random_texts(300, 1'b0, 1'b0, 1'b1);
    test_random_texts(250, 1'b1, 1'b1, 1'b1);
    test_random_texts(250, 1'b0, 1'b1, 1'b1);
    test_random_texts(200, 1'b1, 1'b1, 1'b0);   // closing stretch at full rate

    drain_results();
    $display("covered %0d input words, %0d decoded results, %0d register settings",
             words_sent, results_seen, settings_used);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
